// File: rtl/wlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wlc_pkg;
  localparam int SetCount = 256;
  localparam int WayCount = 4;
  localparam int LineOffsetBits = 6;
  localparam int AddressBits = 48;
  localparam int SetBits = $clog2(SetCount);
  localparam int WayBits = (WayCount > 1) ? $clog2(WayCount) : 1;
  localparam int TagBits = AddressBits - LineOffsetBits - SetBits;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_INVALID   = 2'd0,
    ST_EXCLUSIVE = 2'd1,
    ST_MODIFIED  = 2'd2,
    ST_SPARE     = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_CPU  = 1'b0,
    REG_EMIT = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_UPDATE,
    S_WB,
    S_FILL
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic read_set;
    logic clear_row;
    logic update;
    logic show_wb;
    logic show_fill;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic ignore;
    logic need_wb;
    logic need_fill;
  } ctl_sts_t;
endpackage
`default_nettype wire

// File: rtl/wlc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module wlc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output wlc_pkg::ctl_cmd_t      cmd_o,
  input  wire wlc_pkg::ctl_sts_t sts_i
);
  import wlc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.clear_done) state_d = S_IDLE;
      S_IDLE: if (in_valid_i) state_d = S_READ;
      S_READ: state_d = S_UPDATE;
      S_UPDATE: begin
        priority if (sts_i.ignore) state_d = S_IDLE;
        else if (sts_i.need_wb) state_d = S_WB;
        else if (sts_i.need_fill) state_d = S_FILL;
        else state_d = S_IDLE;
      end
      S_WB: if (out_ready_i) state_d = sts_i.need_fill ? S_FILL : S_IDLE;
      S_FILL: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.clear_row = 1'b1;
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_READ: cmd_o.read_set = 1'b1;
      S_UPDATE: cmd_o.update = 1'b1;
      S_WB: begin
        out_valid_o = 1'b1;
        cmd_o.show_wb = 1'b1;
      end
      S_FILL: begin
        out_valid_o = 1'b1;
        cmd_o.show_fill = 1'b1;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/wlc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module wlc_dpath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wlc_pkg::ctl_cmd_t cmd_i,
  output wlc_pkg::ctl_sts_t      sts_o,
  input  wire logic              emit_i,
  input  wire logic [1:0]        action_i,
  input  wire logic [47:0]       phys_address_i,
  input  wire logic [63:0]       space_tag_i,
  input  wire logic [63:0]       time_stamp_i,
  output logic                   record_kind_o,
  output logic [47:0]            line_address_o,
  output logic [63:0]            record_space_o,
  output logic [63:0]            record_time_o,
  output logic                   last_record_o
);
  import wlc_pkg::*;

  localparam int RowBits = WayCount * (2 + WayBits);
  localparam int TagRowBits = WayCount * TagBits;

  // tag row and status/age row, one of each per set
  logic [TagRowBits-1:0] tag_mem [SetCount];
  logic [RowBits-1:0]    row_mem [SetCount];

  logic [1:0]            act_q;
  logic [TagBits-1:0]    tag_q;
  logic [SetBits-1:0]    set_q;
  logic [63:0]           space_q, time_q;
  logic [SetBits:0]      clr_q;
  logic [RowBits-1:0]    row_q;
  logic [TagRowBits-1:0] tag_row_q;
  logic [TagBits-1:0]    rtag [WayCount];
  logic [TagBits-1:0]    wb_tag_q;
  logic                  need_fill_q;

  logic [AddressBits-1:0] addr_m;
  assign addr_m = phys_address_i[AddressBits-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_i;
      tag_q   <= addr_m[AddressBits-1 -: TagBits];
      set_q   <= addr_m[LineOffsetBits +: SetBits];
      space_q <= space_tag_i;
      time_q  <= time_stamp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_row && !clr_q[SetBits]) begin
      clr_q <= clr_q + 1'b1;
    end
  end
  assign sts_o.clear_done = clr_q[SetBits];

  // reset row: all invalid, age equals way index
  function automatic logic [RowBits-1:0] reset_row();
    logic [RowBits-1:0] r;
    r = '0;
    for (int w = 0; w < WayCount; w++) begin
      r[w*(2+WayBits) +: (2+WayBits)] = {WayBits'(w), ST_INVALID};
    end
    return r;
  endfunction

  always_comb begin
    for (int w = 0; w < WayCount; w++) begin
      rtag[w] = tag_row_q[w*TagBits +: TagBits];
    end
  end

  // lookup on registered row
  logic [WayCount-1:0] hit_v, inv_v, old_v;
  logic [WayBits-1:0]  hit_w, inv_w, old_w, vic_w, sel_w;
  logic                hit, any_inv;
  logic [1:0]          st [WayCount];
  logic [WayBits-1:0]  age [WayCount];

  always_comb begin
    for (int w = 0; w < WayCount; w++) begin
      st[w]  = row_q[w*(2+WayBits) +: 2];
      age[w] = row_q[w*(2+WayBits)+2 +: WayBits];
      hit_v[w] = (st[w] != ST_INVALID) && (rtag[w] == tag_q);
      inv_v[w] = (st[w] == ST_INVALID);
      old_v[w] = (age[w] == WayBits'(WayCount-1));
    end
    hit = |hit_v;
    any_inv = |inv_v;
    hit_w = '0;
    inv_w = '0;
    old_w = '0;
    for (int w = WayCount-1; w >= 0; w--) begin
      if (hit_v[w]) hit_w = WayBits'(w);
      if (inv_v[w]) inv_w = WayBits'(w);
      if (old_v[w]) old_w = WayBits'(w);
    end
    vic_w = any_inv ? inv_w : old_w;
    sel_w = hit ? hit_w : vic_w;
  end

  logic is_flush, is_acc;
  assign is_flush = (act_q == ACT_FLUSH);
  assign is_acc = (act_q == ACT_READ) || (act_q == ACT_WRITE);

  logic [RowBits-1:0] new_row;
  always_comb begin
    new_row = row_q;
    if (is_flush) begin
      if (hit) new_row[hit_w*(2+WayBits) +: 2] = ST_INVALID;
    end else begin
      for (int w = 0; w < WayCount; w++) begin
        if (age[w] < age[sel_w]) begin
          new_row[w*(2+WayBits)+2 +: WayBits] = age[w] + 1'b1;
        end
      end
      new_row[sel_w*(2+WayBits)+2 +: WayBits] = '0;
      if (act_q == ACT_WRITE) new_row[sel_w*(2+WayBits) +: 2] = ST_MODIFIED;
      else if (!hit) new_row[sel_w*(2+WayBits) +: 2] = ST_EXCLUSIVE;
    end
  end

  // victim tag replaced in the row read for this set
  logic [TagRowBits-1:0] new_tag_row;
  always_comb begin
    new_tag_row = tag_row_q;
    new_tag_row[vic_w*TagBits +: TagBits] = tag_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_row && !clr_q[SetBits]) begin
      row_mem[clr_q[SetBits-1:0]] <= reset_row();
    end else if (cmd_i.update && (is_flush || is_acc)) begin
      row_mem[set_q] <= new_row;
    end
    if (cmd_i.update && is_acc && !hit) begin
      tag_mem[set_q] <= new_tag_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_set) begin
      row_q <= row_mem[set_q];
      tag_row_q <= tag_mem[set_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      wb_tag_q <= is_flush ? tag_q : rtag[vic_w];
      need_fill_q <= emit_i && is_acc && !hit;
    end
  end

  assign sts_o.ignore = !(is_flush || is_acc);
  assign sts_o.need_wb = emit_i && ((is_flush && hit && st[hit_w] == ST_MODIFIED)
                         || (is_acc && !hit && st[vic_w] == ST_MODIFIED));
  assign sts_o.need_fill = cmd_i.update ? (emit_i && is_acc && !hit) : need_fill_q;

  logic [AddressBits-1:0] wb_addr, own_addr;
  assign wb_addr = {wb_tag_q, set_q, {LineOffsetBits{1'b0}}};
  assign own_addr = {tag_q, set_q, {LineOffsetBits{1'b0}}};

  assign record_kind_o = cmd_i.show_wb;
  assign line_address_o = 48'(cmd_i.show_wb ? wb_addr : own_addr);
  assign record_space_o = space_q;
  assign record_time_o = time_q;
  assign last_record_o = cmd_i.show_fill || !need_fill_q;
endmodule
`default_nettype wire

// File: rtl/writeback_lru_cache_trace.sv
// an item emits up to two records, a writeback before a fill; the next item
// is accepted only once the last record of the one before has been taken
// the set's tag/status/age row is read, then written back, one port each
// after reset a clearing pass over every set (one set per cycle) runs before
// the first item is accepted; config writes are taken at any time
`timescale 1ns / 1ps
`default_nettype none
module writeback_lru_cache_trace (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [47:0] phys_address_i,
  input  wire logic [63:0] space_tag_i,
  input  wire logic [63:0] time_stamp_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             record_kind_o,
  output logic [47:0]      line_address_o,
  output logic [63:0]      record_space_o,
  output logic [63:0]      record_time_o,
  output logic [6:0]       record_cpu_o,
  output logic             last_record_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [6:0]  cfg_data_i
);
  import wlc_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic [6:0] cpu_q;
  logic emit_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_q <= '0;
      emit_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_CPU: cpu_q <= cfg_data_i;
        REG_EMIT: emit_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end
  assign record_cpu_o = cpu_q;

  wlc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  wlc_dpath u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .emit_i(emit_q),
    .action_i, .phys_address_i, .space_tag_i, .time_stamp_i,
    .record_kind_o, .line_address_o, .record_space_o, .record_time_o,
    .last_record_o
  );
endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import wlc_pkg::*;

  typedef struct {
    logic        kind;
    logic [47:0] addr;
    logic [63:0] space;
    logic [63:0] stamp;
    logic [6:0]  cpu;
    logic        last;
  } trace_rec_t;

  // shadow cache and expected traffic records
  class traffic_board;
    logic [TagBits-1:0] tags[SetCount*WayCount];
    logic [1:0]         status[SetCount*WayCount];
    int                 age[SetCount*WayCount];
    logic [6:0]         cpu;
    logic               emit;
    trace_rec_t         pending[$];
    int                 errors;

    function void clear_state();
      for (int i = 0; i < SetCount * WayCount; i++) begin
        tags[i] = '0;
        status[i] = ST_INVALID;
        age[i] = i % WayCount;
      end
      cpu = '0;
      emit = 1'b1;
      errors = 0;
    endfunction

    function void make_mru(int base, int way);
      int old;
      old = age[base + way];
      for (int w = 0; w < WayCount; w++)
        if (age[base + w] < old) age[base + w]++;
      age[base + way] = 0;
    endfunction

    function void push_rec(logic kind, logic [47:0] addr, logic [63:0] sp,
                           logic [63:0] ts, logic last);
      trace_rec_t r;
      r.kind = kind;
      r.addr = addr;
      r.space = sp;
      r.stamp = ts;
      r.cpu = cpu;
      r.last = last;
      pending.push_back(r);
    endfunction

    function void note_access(logic [1:0] act, logic [47:0] pa, logic [63:0] sp,
                              logic [63:0] ts);
      logic [47:0]        lnum;
      logic [SetBits-1:0] set;
      logic [TagBits-1:0] tag;
      int base, hit, victim;
      lnum = pa >> LineOffsetBits;
      set = lnum[SetBits-1:0];
      tag = TagBits'(lnum >> SetBits);
      base = int'(set) * WayCount;
      hit = -1;
      victim = -1;
      if (act == ACT_NONE) return;
      for (int w = 0; w < WayCount; w++)
        if (hit < 0 && status[base + w] != ST_INVALID && tags[base + w] == tag) hit = w;
      if (act == ACT_FLUSH) begin
        if (hit >= 0) begin
          if (status[base + hit] == ST_MODIFIED && emit)
            push_rec(1'b1, lnum << LineOffsetBits, sp, ts, 1'b1);
          status[base + hit] = ST_INVALID;
        end
        return;
      end
      if (hit >= 0) begin
        make_mru(base, hit);
        if (act == ACT_WRITE) status[base + hit] = ST_MODIFIED;
        return;
      end
      for (int w = 0; w < WayCount; w++)
        if (victim < 0 && status[base + w] == ST_INVALID) victim = w;
      for (int w = 0; w < WayCount; w++)
        if (victim < 0 && age[base + w] == WayCount - 1) victim = w;
      if (status[base + victim] == ST_MODIFIED && emit)
        push_rec(1'b1, 48'({tags[base + victim], set}) << LineOffsetBits, sp, ts, 1'b0);
      tags[base + victim] = tag;
      status[base + victim] = (act == ACT_WRITE) ? ST_MODIFIED : ST_EXCLUSIVE;
      make_mru(base, victim);
      if (emit) push_rec(1'b0, lnum << LineOffsetBits, sp, ts, 1'b1);
    endfunction

    function void check_record(trace_rec_t got);
      trace_rec_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected record kind=%0d addr=%h", $time, got.kind, got.addr);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind) begin
        $display("%0t: record_kind exp %0d got %0d", $time, exp.kind, got.kind);
        errors++;
      end
      if (got.addr !== exp.addr) begin
        $display("%0t: line_address exp %h got %h", $time, exp.addr, got.addr);
        errors++;
      end
      if (got.space !== exp.space) begin
        $display("%0t: record_space exp %h got %h", $time, exp.space, got.space);
        errors++;
      end
      if (got.stamp !== exp.stamp) begin
        $display("%0t: record_time exp %h got %h", $time, exp.stamp, got.stamp);
        errors++;
      end
      if (got.cpu !== exp.cpu) begin
        $display("%0t: record_cpu exp %0d got %0d", $time, exp.cpu, got.cpu);
        errors++;
      end
      if (got.last !== exp.last) begin
        $display("%0t: last_record exp %0d got %0d", $time, exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [47:0] phys_address_i = '0;
  logic [63:0] space_tag_i = '0;
  logic [63:0] time_stamp_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        record_kind_o;
  logic [47:0] line_address_o;
  logic [63:0] record_space_o;
  logic [63:0] record_time_o;
  logic [6:0]  record_cpu_o;
  logic        last_record_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [6:0]  cfg_data_i = '0;

  traffic_board board;
  int  idle_cycles = 0;
  bit  stall_free = 1'b0;
  localparam int IdleLimit = 20000;

  writeback_lru_cache_trace DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sample handshakes at the rising edge
  always @(posedge clk_i) begin
    trace_rec_t r;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        board.note_access(action_i, phys_address_i, space_tag_i, time_stamp_i);
      if (out_valid_o && out_ready_i) begin
        r.kind = record_kind_o;
        r.addr = line_address_o;
        r.space = record_space_o;
        r.stamp = record_time_o;
        r.cpu = record_cpu_o;
        r.last = last_record_o;
        board.check_record(r);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver stall pattern: periodic windows plus random stalls
  always @(negedge clk_i) begin
    int phase;
    phase = int'(($time / 10) % 64);
    if (stall_free) out_ready_i <= 1'b1;
    else if (phase < 16) out_ready_i <= 1'b1;
    else if (phase < 24) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  task automatic write_reg(reg_e idx, logic [6:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_CPU) board.cpu = data;
    else board.emit = data[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // drive one access; caller decides about gaps
  task automatic send_access(logic [1:0] act, logic [47:0] pa, bit keep_valid);
    action_i <= act;
    phys_address_i <= pa;
    space_tag_i <= {$urandom, $urandom};
    time_stamp_i <= {$urandom, $urandom};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (!keep_valid) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [47:0] make_addr(int tag_sel, int set_sel);
    logic [TagBits-1:0] t;
    t = TagBits'(tag_sel);
    return {t, set_sel[SetBits-1:0], 6'(($urandom))};
  endfunction

  // random phase: a few hot sets with a small tag pool to force evictions
  task automatic random_phase(int count);
    int burst;
    logic [1:0] act;
    logic [47:0] pa;
    int sel;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) act = ACT_READ;
      else if (sel < 85) act = ACT_WRITE;
      else if (sel < 97) act = ACT_FLUSH;
      else act = ACT_NONE;
      if ($urandom_range(0, 9) == 0) pa = 48'({$urandom, $urandom});
      else pa = make_addr($urandom_range(0, 7), $urandom_range(0, 3) * 85);
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if (!stall_free) begin
          repeat ($urandom_range(0, 6)) @(negedge clk_i);
        end
      end
      burst--;
      send_access(act, pa, (burst != 0) && (i != count - 1));
    end
  endtask

  initial begin
    board = new();
    board.clear_state();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: fill one set past capacity with writes, hit, flush, extremes
    stall_free = 1'b1;
    write_reg(REG_CPU, 7'h7f);
    for (int t = 0; t < 6; t++) send_access(ACT_WRITE, make_addr(t, 0), 1'b0);
    send_access(ACT_READ, make_addr(5, 0), 1'b0);
    send_access(ACT_WRITE, make_addr(4, 0), 1'b0);
    send_access(ACT_FLUSH, make_addr(5, 0), 1'b0);
    send_access(ACT_FLUSH, make_addr(4, 0), 1'b0);
    send_access(ACT_FLUSH, make_addr(9, 0), 1'b0);
    send_access(ACT_NONE, make_addr(3, 0), 1'b0);
    send_access(ACT_READ, 48'hffff_ffff_ffff, 1'b0);
    send_access(ACT_WRITE, 48'h0, 1'b0);
    send_access(ACT_READ, 48'haaaa_aaaa_aaaa, 1'b0);
    send_access(ACT_WRITE, 48'h5555_5555_5555, 1'b0);
    send_access(ACT_FLUSH, 48'hffff_ffff_ffc0, 1'b0);
    drain();

    stall_free = 1'b0;
    write_reg(REG_CPU, 7'h00);
    random_phase(150);
    drain();
    write_reg(REG_EMIT, 7'd0);
    write_reg(REG_CPU, 7'h2a);
    random_phase(60);
    drain();
    write_reg(REG_EMIT, 7'd1);
    random_phase(120);
    stall_free = 1'b1;
    random_phase(100);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
